// ===== hw/rtl/gck_pkg.sv =====
package gck_pkg;

	// Vertex ids on the item channel are six bits wide, so at most this many vertices exist.
	localparam int ID_SPACE = 64;

	// Default sizes for the top level.
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_COLORS   = 64;

	// Vertex count after reset.
	localparam logic [6:0] CFG_RESET_COUNT = 7'd64;

	// Item kinds.
	typedef enum logic [1:0] {
		KIND_ADD_EDGE   = 2'd0,
		KIND_FIRST_FIT  = 2'd1,
		KIND_KEMPE_SWAP = 2'd2,
		KIND_READ       = 2'd3
	} kind_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_RD_A,
		ST_ADD_WR_A,
		ST_ADD_WR_B,
		ST_ELIG,
		ST_BFS,
		ST_RECOLOR,
		ST_SAT_ROW,
		ST_SAT_SCAN,
		ST_FF_SEARCH,
		ST_RD_COLOR,
		ST_OUT_LOAD
	} state_t;

	// Payload of one input beat.
	typedef struct packed {
		kind_t      kind;
		logic [5:0] vertex_a;
		logic [5:0] vertex_b;
		logic [5:0] color_one;
		logic [5:0] color_two;
	} item_t;

	// Payload of one result beat.
	typedef struct packed {
		logic signed [6:0] vertex_color;
		logic [6:0]        saturation;
		logic [6:0]        moved_count;
	} result_t;

	// Payload of one configuration beat.
	typedef logic [6:0] cfg_word_t;

endpackage

// ===== hw/rtl/gck_chan_if.sv =====
// Valid/ready channel carrying one payload per beat.
interface gck_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/graph_coloring_kempe_engine.sv =====
// Graph colouring engine: holds an undirected graph as one adjacency row per vertex and a colour
// per vertex, and executes one item at a time: add edge, first-fit colour, Kempe chain swap or
// read. Every item returns exactly one result beat (colour of vertex_a, its saturation and, for a
// swap, the number of recoloured vertices). All work runs through a small sequencer that sweeps
// the vertices one per cycle through a single read port of the adjacency memory and of the colour
// memory; the item port is ready only while the sequencer is idle, and a finished result waits in
// an output register so the next item can be taken meanwhile. A Kempe swap makes breadth passes
// over the adjacency rows until a pass expands no new member: at least two, at most two more than
// the chain depth. Both stores come out of reset empty at once through per-entry valid bits; no
// clearing pass is needed. The configuration write port is always ready.
module graph_coloring_kempe_engine #(
	parameter int MAX_VERTICES = gck_pkg::DEF_MAX_VERTICES,
	parameter int MAX_COLORS   = gck_pkg::DEF_MAX_COLORS
) (
	input  logic      clk,
	input  logic      arst_n,
	gck_chan_if.sink   item,
	gck_chan_if.source result,
	gck_chan_if.sink   cfg
);
	import gck_pkg::*;

	// Only as many vertices as the id space can name are stored.
	localparam int NV   = (MAX_VERTICES < ID_SPACE) ? MAX_VERTICES : ID_SPACE;
	localparam int AW   = $clog2(NV);
	localparam int CNTW = $clog2(NV + 1);
	localparam int CW   = $clog2(MAX_COLORS);
	localparam int CCW  = $clog2(MAX_COLORS + 1);

	state_t state_q, state_d;

	logic [6:0]      cfg_q;
	logic [CNTW-1:0] lim;

	// Captured item.
	kind_t         kind_q;
	logic [AW-1:0] a_q;
	logic [AW-1:0] b_q;
	logic [CW-1:0] c1_q;
	logic [CW-1:0] c2_q;
	logic          skip_q;

	// Sweep counter and read pipeline tag.
	logic [CNTW-1:0] cnt_q;
	logic            cnt_rst;
	logic            cnt_inc;
	logic            last;
	logic            scan_s1;
	logic [AW-1:0]   idx_s1;

	// Adjacency memory.
	logic [NV-1:0] adj_mem [NV];
	logic [NV-1:0] adj_vld_q;
	logic [NV-1:0] adj_rd_s1;
	logic          adjv_s1;
	logic [NV-1:0] row_s1;
	logic          adj_re, adj_we;
	logic [AW-1:0] adj_ra, adj_wa;
	logic [NV-1:0] adj_wd;

	// Colour memory.
	logic [CW-1:0] col_mem [NV];
	logic [NV-1:0] col_vld_q;
	logic [CW-1:0] col_s1;
	logic          colv_s1;
	logic          col_re, col_we;
	logic [AW-1:0] col_ra, col_wa;
	logic [CW-1:0] col_wd;

	// Kempe chain working sets.
	logic [NV-1:0] eligible_q;
	logic [NV-1:0] members_q;
	logic [NV-1:0] expanded_q;
	logic          bfs_chg_q;
	logic          grow;
	logic [CW-1:0] new_col;
	logic          col_changes;
	logic [CNTW-1:0] moved_q;

	// Neighbour colour set and first-fit search.
	logic [MAX_COLORS-1:0] seen_q;
	logic [CCW-1:0]        sat_q;
	logic [CCW-1:0]        ccnt_q;
	logic                  ff_none;
	logic                  ff_hit;

	logic [NV-1:0] bit_a, bit_b;

	// Decoded item checks.
	logic item_acc;
	logic a_ok, b_ok, kempe_ok;

	logic    res_valid_q;
	result_t res_q;
	logic    res_load;

	// Active vertex limit.
	always_comb begin
		if (cfg_q > 7'(NV)) begin
			lim = CNTW'(NV);
		end else begin
			lim = CNTW'(cfg_q);
		end
	end

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign a_ok = 7'(item.data.vertex_a) < 7'(lim);
	assign b_ok = (7'(item.data.vertex_b) < 7'(lim)) &&
		(item.data.vertex_b != item.data.vertex_a);
	assign kempe_ok = (7'(item.data.color_one) < 7'(MAX_COLORS)) &&
		(7'(item.data.color_two) < 7'(MAX_COLORS));

	assign last   = (cnt_q == lim);
	assign row_s1 = adjv_s1 ? adj_rd_s1 : '0;
	assign bit_a  = {{(NV-1){1'b0}}, 1'b1} << a_q;
	assign bit_b  = {{(NV-1){1'b0}}, 1'b1} << b_q;

	// A breadth step: an unexpanded chain member whose row has just been read.
	assign grow = scan_s1 && members_q[idx_s1] && !expanded_q[idx_s1];

	// Recolour rule for one chain member.
	assign new_col     = (colv_s1 && (col_s1 == c2_q)) ? c1_q : c2_q;
	assign col_changes = !(colv_s1 && (col_s1 == new_col));

	assign ff_none = (ccnt_q == CCW'(MAX_COLORS));
	assign ff_hit  = !ff_none && !seen_q[ccnt_q[CW-1:0]];

	assign res_load = (state_q == ST_OUT_LOAD) && (!res_valid_q || result.ready);

	// Next state and memory port control.
	always_comb begin
		state_d = state_q;
		cnt_rst = 1'b0;
		cnt_inc = 1'b0;
		adj_re  = 1'b0;
		adj_ra  = a_q;
		adj_we  = 1'b0;
		adj_wa  = a_q;
		adj_wd  = row_s1 | bit_b;
		col_re  = 1'b0;
		col_ra  = cnt_q[AW-1:0];
		col_we  = 1'b0;
		col_wa  = idx_s1;
		col_wd  = new_col;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					if (!a_ok) begin
						state_d = ST_OUT_LOAD;
					end else begin
						unique case (item.data.kind)
							KIND_ADD_EDGE:   state_d = b_ok ? ST_ADD_RD_A : ST_SAT_ROW;
							KIND_KEMPE_SWAP: state_d = kempe_ok ? ST_ELIG : ST_SAT_ROW;
							KIND_FIRST_FIT,
							KIND_READ:       state_d = ST_SAT_ROW;
							default:         state_d = ST_SAT_ROW;
						endcase
					end
				end
			end
			ST_ADD_RD_A: begin
				adj_re  = 1'b1;
				state_d = ST_ADD_WR_A;
			end
			ST_ADD_WR_A: begin
				adj_we  = 1'b1;
				adj_re  = 1'b1;
				adj_ra  = b_q;
				state_d = ST_ADD_WR_B;
			end
			ST_ADD_WR_B: begin
				adj_we  = 1'b1;
				adj_wa  = b_q;
				adj_wd  = row_s1 | bit_a;
				state_d = ST_SAT_ROW;
			end
			ST_ELIG: begin
				col_re  = !last;
				cnt_inc = !last;
				if (last) begin
					state_d = ST_BFS;
				end
			end
			ST_BFS: begin
				adj_re  = !last;
				adj_ra  = cnt_q[AW-1:0];
				cnt_inc = !last;
				if (last) begin
					if (bfs_chg_q || grow) begin
						cnt_rst = 1'b1;
					end else begin
						state_d = ST_RECOLOR;
					end
				end
			end
			ST_RECOLOR: begin
				col_re  = !last;
				cnt_inc = !last;
				col_we  = scan_s1 && members_q[idx_s1];
				if (last) begin
					state_d = ST_SAT_ROW;
				end
			end
			ST_SAT_ROW: begin
				adj_re  = 1'b1;
				state_d = ST_SAT_SCAN;
			end
			ST_SAT_SCAN: begin
				col_re  = !last;
				cnt_inc = !last;
				if (last) begin
					state_d = (kind_q == KIND_FIRST_FIT) ? ST_FF_SEARCH : ST_RD_COLOR;
				end
			end
			ST_FF_SEARCH: begin
				col_wa = a_q;
				col_wd = ccnt_q[CW-1:0];
				if (ff_none) begin
					state_d = ST_RD_COLOR;
				end else if (ff_hit) begin
					col_we  = 1'b1;
					state_d = ST_RD_COLOR;
				end
			end
			ST_RD_COLOR: begin
				col_re  = 1'b1;
				col_ra  = a_q;
				state_d = ST_OUT_LOAD;
			end
			ST_OUT_LOAD: begin
				if (!res_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers, configuration and store valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_RESET_COUNT;
			cnt_q       <= '0;
			scan_s1     <= 1'b0;
			res_valid_q <= 1'b0;
			adj_vld_q   <= '0;
			col_vld_q   <= '0;
		end else begin
			state_q <= state_d;
			scan_s1 <= cnt_inc;
			if (cfg.valid) begin
				cfg_q <= cfg.data;
			end
			if ((state_q != state_d) || cnt_rst) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (adj_we) begin
				adj_vld_q[adj_wa] <= 1'b1;
			end
			if (col_we) begin
				col_vld_q[col_wa] <= 1'b1;
			end
		end
	end

	// Adjacency memory with registered read.
	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_wa] <= adj_wd;
		end
		if (adj_re) begin
			adj_rd_s1 <= adj_mem[adj_ra];
			adjv_s1   <= adj_vld_q[adj_ra];
		end
	end

	// Colour memory with registered read.
	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_wa] <= col_wd;
		end
		if (col_re) begin
			col_s1  <= col_mem[col_ra];
			colv_s1 <= col_vld_q[col_ra];
		end
	end

	// Working registers of the sweeps.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		if (item_acc) begin
			kind_q     <= item.data.kind;
			a_q        <= item.data.vertex_a[AW-1:0];
			b_q        <= item.data.vertex_b[AW-1:0];
			c1_q       <= item.data.color_one[CW-1:0];
			c2_q       <= item.data.color_two[CW-1:0];
			skip_q     <= !a_ok;
			members_q  <= {{(NV-1){1'b0}}, 1'b1} << item.data.vertex_a[AW-1:0];
			expanded_q <= '0;
			eligible_q <= '0;
			bfs_chg_q  <= 1'b0;
			moved_q    <= '0;
			seen_q     <= '0;
			sat_q      <= '0;
			ccnt_q     <= '0;
		end

		// Vertices that may join the chain.
		if ((state_q == ST_ELIG) && scan_s1) begin
			eligible_q[idx_s1] <= colv_s1 && ((col_s1 == c1_q) || (col_s1 == c2_q));
		end

		// Breadth pass: expand each new member once.
		if (state_q == ST_BFS) begin
			if (grow) begin
				expanded_q[idx_s1] <= 1'b1;
				members_q          <= members_q | (row_s1 & eligible_q);
			end
			if (cnt_rst) begin
				bfs_chg_q <= 1'b0;
			end else if (grow) begin
				bfs_chg_q <= 1'b1;
			end
		end

		// Count members whose colour really changes.
		if ((state_q == ST_RECOLOR) && scan_s1 && members_q[idx_s1] && col_changes) begin
			moved_q <= moved_q + 1'b1;
		end

		// Distinct colours among assigned neighbours.
		if ((state_q == ST_SAT_SCAN) && scan_s1 && row_s1[idx_s1] && colv_s1 &&
			!seen_q[col_s1]) begin
			seen_q[col_s1] <= 1'b1;
			sat_q          <= sat_q + 1'b1;
		end

		// Lowest free colour search.
		if ((state_q == ST_FF_SEARCH) && !ff_none && !ff_hit) begin
			ccnt_q <= ccnt_q + 1'b1;
		end

		// Result register.
		if (res_load) begin
			if (skip_q) begin
				res_q.vertex_color <= -7'sd1;
				res_q.saturation   <= '0;
				res_q.moved_count  <= '0;
			end else begin
				res_q.vertex_color <= colv_s1 ? $signed({{(7-CW){1'b0}}, col_s1}) : -7'sd1;
				res_q.saturation   <= 7'(sat_q);
				res_q.moved_count  <= 7'(moved_q);
			end
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule
